### hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### hw/rtl/fldre_pkg.sv
// Package for the radix digit emitter: field widths, mode codes, ASCII constants.
// No dependencies.
package fldre_pkg;

  // Field widths of the input and result items
  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int LINE_W  = 3;
  localparam int SCOL_W  = 5;
  localparam int CHAR_W  = 7;
  localparam int COL_W   = 6;

  // Digit limits per mode
  localparam int DEC_LIMIT = 10;
  localparam int HEX_LIMIT = 8;
  localparam int BCD_W     = 4 * DEC_LIMIT;

  localparam logic [3:0] DEC_RADIX = 4'd10;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

  typedef enum logic [KIND_W-1:0] {
    KIND_UDEC = 2'd0,
    KIND_SDEC = 2'd1,
    KIND_HEX  = 2'd2,
    KIND_BIN  = 2'd3
  } kind_e;

  // Run description handed from the top level to the character sequencer
  typedef struct packed {
    kind_e              kind;
    logic               neg;
    logic [LINE_W-1:0]  line;
    logic [SCOL_W-1:0]  col;
  } job_t;

endpackage

### hw/rtl/fldre_if.sv
// Valid/ready channel interfaces for the number items and the character items.
// Depends on fldre_pkg.
interface fldre_in_if import fldre_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] digit_count;
  logic [LINE_W-1:0]  line;
  logic [SCOL_W-1:0]  start_column;

  modport source (output valid, kind, value, digit_count, line, start_column, input ready);
  modport sink   (input valid, kind, value, digit_count, line, start_column, output ready);
endinterface

interface fldre_out_if import fldre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic [LINE_W-1:0] out_line;
  logic [COL_W-1:0]  column;
  logic              last;

  modport source (output valid, char_code, out_line, column, last, input ready);
  modport sink   (input valid, char_code, out_line, column, last, output ready);
endinterface

### hw/rtl/fixed_length_radix_digit_emitter_top.sv
// Radix digit emitter: turns one number item into a run of ASCII character items.
// Usage:
//   in_i  takes one number item (kind, value, digit_count, line, start_column).
//   out_o gives one character item per cycle at best, with line, column, last.
// Modes: unsigned decimal, signed decimal (sign first), uppercase hex, binary.
// Only the lowest digit_count digits are shown; the count saturates per mode.
// Timing:
//   Hex and binary: the sequencer loads the run at the accept, then the output register.
//   Decimal: a bit-serial shift and add-3 converter runs first, and the
//   sequencer loads the run on its done pulse, then the output register.
// One item is in work at a time: in_i.ready is high only when the previous run
// is fully delivered. A stall on out_o holds the current character in the
// output register and pauses the run.
// Reset clears the sequencer; the block is ready right after reset.
// Depends on fldre_pkg, fldre_if, fldre_bcd, fldre_emit.
module fixed_length_radix_digit_emitter_top import fldre_pkg::*; #(
  parameter int MAX_DIGITS  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fldre_in_if.sink    in_i,
  fldre_out_if.source out_o
);

  localparam int MAX_CNT = (MAX_DIGITS > DEC_LIMIT) ? MAX_DIGITS : DEC_LIMIT;
  localparam int CNT_W   = $clog2(MAX_CNT + 1);
  localparam int SRC_A   = (BCD_W > MAX_DIGITS + 3) ? BCD_W : MAX_DIGITS + 3;
  localparam int SRC_W   = (SRC_A > VALUE_WIDTH) ? SRC_A : VALUE_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  job_t                   job_q;
  logic [CNT_W-1:0]       cnt_q;

  kind_e                  in_kind;
  logic                   in_fire;
  logic                   in_dec;
  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  int                     limit;
  logic [CNT_W-1:0]       cnt_sat;
  job_t                   in_job;

  logic                   bcd_done;
  logic [BCD_W-1:0]       bcd;
  logic                   emit_start;
  job_t                   emit_job;
  logic [CNT_W-1:0]       emit_cnt;
  logic [SRC_W-1:0]       emit_src;
  logic                   emit_busy;

  // Input decode: saturated count, sign and magnitude
  always_comb begin
    in_kind = kind_e'(in_i.kind);
    in_fire = in_i.valid && in_i.ready;
    in_dec  = (in_kind == KIND_UDEC) || (in_kind == KIND_SDEC);
    val     = in_i.value[VALUE_WIDTH-1:0];
    neg     = (in_kind == KIND_SDEC) && val[VALUE_WIDTH-1];
    mag     = neg ? (~val + 1'b1) : val;
    unique case (in_kind)
      KIND_HEX: limit = HEX_LIMIT;
      KIND_BIN: limit = MAX_DIGITS;
      default:  limit = DEC_LIMIT;
    endcase
    cnt_sat = (int'(in_i.digit_count) > limit) ? CNT_W'(limit) : CNT_W'(in_i.digit_count);
    in_job.kind = in_kind;
    in_job.neg  = neg;
    in_job.line = in_i.line;
    in_job.col  = in_i.start_column;
  end

  // Sequencer start: hex and binary at once, decimal after conversion
  always_comb begin
    emit_start = (in_fire && !in_dec) || ((state_q == ST_CONV) && bcd_done);
    if (state_q == ST_CONV) begin
      emit_job = job_q;
      emit_cnt = cnt_q;
      emit_src = SRC_W'(bcd);
    end else begin
      emit_job = in_job;
      emit_cnt = cnt_sat;
      emit_src = SRC_W'(mag);
    end
  end

  // Item state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = in_dec ? ST_CONV : ST_EMIT;
      ST_CONV: if (bcd_done) state_d = ST_EMIT;
      ST_EMIT: if (!emit_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Run fields held across the decimal conversion
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_q <= in_job;
      cnt_q <= cnt_sat;
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);

  fldre_bcd #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire && in_dec),
    .value_i (mag),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  fldre_emit #(
    .CNT_W (CNT_W),
    .SRC_W (SRC_W)
  ) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (emit_start),
    .job_i   (emit_job),
    .cnt_i   (emit_cnt),
    .src_i   (emit_src),
    .busy_o  (emit_busy),
    .out_o   (out_o)
  );

endmodule

### hw/rtl/fldre_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on fldre_pkg.
module fldre_bcd import fldre_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   done_o,
  output logic [BCD_W-1:0]       bcd_o
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] bin_q;
  logic [BCD_W-1:0]       bcd_q;
  logic [BCD_W-1:0]       adj;
  logic [CW-1:0]          cnt_q;
  logic                   done_q;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_LIMIT; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  // Shift counter; done pulses after the last bit went in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(VALUE_WIDTH);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift registers, MSB of the binary word first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (cnt_q != '0) begin
      bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
      bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

### hw/rtl/fldre_emit.sv
// Character sequencer: sign, then digits most significant first, through an output register.
// Depends on fldre_pkg and fldre_out_if.
module fldre_emit import fldre_pkg::*; #(
  parameter int CNT_W = 5,
  parameter int SRC_W = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  job_t               job_i,
  input  logic [CNT_W-1:0]   cnt_i,
  input  logic [SRC_W-1:0]   src_i,
  output logic               busy_o,
  fldre_out_if.source        out_o
);

  localparam int IDX_W = $clog2(SRC_W);

  kind_e             kind_q;
  logic              neg_q;
  logic [LINE_W-1:0] line_q;
  logic [SRC_W-1:0]  src_q;
  logic [COL_W-1:0]  col_q;
  logic              sign_pend_q;
  logic [CNT_W-1:0]  rem_q;
  logic              ovalid_q;
  logic [CHAR_W-1:0] char_q;
  logic [LINE_W-1:0] oline_q;
  logic [COL_W-1:0]  ocol_q;
  logic              last_q;

  logic              gen;
  logic [CNT_W-1:0]  pos;
  logic [IDX_W-1:0]  idx;
  logic [3:0]        nib;
  logic [3:0]        dval;
  logic [CHAR_W-1:0] dchar;
  logic [CHAR_W-1:0] gen_char;
  logic              gen_last;

  // Next character: digit pos = remaining - 1, one bit in binary, one nibble otherwise
  always_comb begin
    gen  = (sign_pend_q || (rem_q != '0)) && (!ovalid_q || out_o.ready);
    pos  = rem_q - 1'b1;
    idx  = (kind_q == KIND_BIN) ? IDX_W'(pos) : IDX_W'({pos, 2'b00});
    nib  = src_q[idx +: 4];
    dval = (kind_q == KIND_BIN) ? {3'b000, nib[0]} : nib;
    dchar = (dval < DEC_RADIX) ? CH_ZERO + CHAR_W'(dval)
                               : CH_A + CHAR_W'(dval - DEC_RADIX);
    if (sign_pend_q) begin
      gen_char = neg_q ? CH_MINUS : CH_PLUS;
      gen_last = (rem_q == '0);
    end else begin
      gen_char = dchar;
      gen_last = (rem_q == CNT_W'(1));
    end
  end

  // Run control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_pend_q <= 1'b0;
      rem_q       <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      if (start_i) begin
        sign_pend_q <= (job_i.kind == KIND_SDEC);
        rem_q       <= cnt_i;
      end else if (gen) begin
        if (sign_pend_q) begin
          sign_pend_q <= 1'b0;
        end else begin
          rem_q <= rem_q - 1'b1;
        end
      end
      if (gen) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Run payload and output register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      kind_q <= job_i.kind;
      neg_q  <= job_i.neg;
      line_q <= job_i.line;
      src_q  <= src_i;
      col_q  <= {1'b0, job_i.col};
    end else if (gen) begin
      col_q   <= col_q + 1'b1;
      char_q  <= gen_char;
      oline_q <= line_q;
      ocol_q  <= col_q;
      last_q  <= gen_last;
    end
  end

  assign busy_o          = sign_pend_q || (rem_q != '0) || ovalid_q;
  assign out_o.valid     = ovalid_q;
  assign out_o.char_code = char_q;
  assign out_o.out_line  = oline_q;
  assign out_o.column    = ocol_q;
  assign out_o.last      = last_q;

endmodule

### hw/rtl/fldre_chk.sv
// Port-level checker for the radix digit emitter and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fldre_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_last_i
);

  // A character waiting for the receiver stays offered
  `ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // No new number is taken while a character is pending
  `ASSERT_IMPLIES(a_no_accept_during_out, in_ready_i, !out_valid_i)

  // One number at a time: ready drops after an accept
  `ASSERT_NEXT(a_ready_drops, in_valid_i && in_ready_i, !in_ready_i)

  // A run is not cut short by a new accept
  `ASSERT_NEXT(a_run_busy, out_valid_i && out_ready_i && !out_last_i, !in_ready_i)

endmodule

bind fixed_length_radix_digit_emitter_top fldre_chk u_fldre_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for fixed_length_radix_digit_emitter_top: drives number items, predicts
// the ASCII character run of each one and checks every character item in order.
// Depends on fldre_pkg, fldre_if and the emitter RTL.
module tb;
  import fldre_pkg::*;

  localparam int MAX_DIG     = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = VALUE_W + 20;

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic [LINE_W-1:0]  line;
    logic [SCOL_W-1:0]  scol;
  } number_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic              last;
  } glyph_t;

  logic clk_i;
  logic rst_ni;

  fldre_in_if  num_if ();
  fldre_out_if chr_if ();

  fixed_length_radix_digit_emitter_top #(
    .MAX_DIGITS  (MAX_DIG),
    .VALUE_WIDTH (VALUE_W)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (num_if),
    .out_o  (chr_if)
  );

  number_t numbers_q[$];
  glyph_t  glyphs_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_reqs;
  int hold_done;
  int hold_left;
  int mismatches;
  int cycles;
  bit num_taken;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Expected character run of one number item
  function automatic void expand_number(number_t n);
    int unsigned lim;
    int unsigned cnt;
    int unsigned pos;
    longint unsigned scale;
    logic [VALUE_W-1:0] mag;
    logic [COL_W-1:0] col;
    logic [3:0] dig;
    glyph_t g;
    case (n.kind)
      KIND_HEX: lim = HEX_LIMIT;
      KIND_BIN: lim = MAX_DIG;
      default:  lim = DEC_LIMIT;
    endcase
    cnt = (n.count > lim) ? lim : n.count;
    mag = n.value;
    col = {1'b0, n.scol};
    // signed mode: sign first, then the magnitude; the most negative value wraps to 2^31
    if (n.kind == KIND_SDEC) begin
      g.code = mag[VALUE_W-1] ? CH_MINUS : CH_PLUS;
      if (mag[VALUE_W-1]) mag = ~mag + 1'b1;
      g.line = n.line;
      g.col  = col;
      g.last = (cnt == 0);
      glyphs_q.push_back(g);
      col = col + 1'b1;
    end
    for (int unsigned i = 0; i < cnt; i++) begin
      pos = cnt - 1 - i;
      case (n.kind)
        KIND_HEX: dig = 4'((mag >> (4 * pos)) & 'hF);
        KIND_BIN: dig = 4'((mag >> pos) & 1);
        default: begin
          scale = 1;
          for (int unsigned k = 0; k < pos; k++) scale = scale * 10;
          dig = 4'((longint'(mag) / scale) % 10);
        end
      endcase
      g.code = (dig < DEC_RADIX) ? CH_ZERO + CHAR_W'(dig) : CH_A + CHAR_W'(dig - DEC_RADIX);
      g.line = n.line;
      g.col  = col + COL_W'(i);
      g.last = (i + 1 == cnt);
      glyphs_q.push_back(g);
    end
  endfunction

  // Number item driver: new item or idle at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!num_if.valid || num_taken)) begin
      if (numbers_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        num_if.valid        <= 1'b1;
        num_if.kind         <= numbers_q[0].kind;
        num_if.value        <= numbers_q[0].value;
        num_if.digit_count  <= numbers_q[0].count;
        num_if.line         <= numbers_q[0].line;
        num_if.start_column <= numbers_q[0].scol;
      end else begin
        num_if.valid <= 1'b0;
      end
    end
  end

  // Character receiver: random stalls plus the long hold-off
  always @(negedge clk_i) begin
    if (hold_reqs != hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = hold_done + 1;
    end
    if (hold_left > 0) begin
      chr_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      chr_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: accepted numbers feed the predictor, accepted characters are checked
  always @(posedge clk_i) begin
    number_t n;
    glyph_t  got;
    glyph_t  want;
    num_taken = 1'b0;
    if (rst_ni) begin
      if (num_if.valid && num_if.ready) begin
        n.kind  = kind_e'(num_if.kind);
        n.value = num_if.value;
        n.count = num_if.digit_count;
        n.line  = num_if.line;
        n.scol  = num_if.start_column;
        expand_number(n);
        void'(numbers_q.pop_front());
        num_taken = 1'b1;
      end
      if (chr_if.valid && chr_if.ready) begin
        got = {chr_if.char_code, chr_if.out_line, chr_if.column, chr_if.last};
        if (glyphs_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected char item: code %h line %0d col %0d last %b",
                     got.code, got.line, got.col, got.last);
        end else begin
          want = glyphs_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("char mismatch: exp code %h line %0d col %0d last %b, got code %h line %0d col %0d last %b",
                       want.code, want.line, want.col, want.last,
                       got.code, got.line, got.col, got.last);
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_number(kind_e kind, logic [VALUE_W-1:0] value, int count, int line,
                            int scol);
    number_t n;
    n.kind  = kind;
    n.value = value;
    n.count = COUNT_W'(count);
    n.line  = LINE_W'(line);
    n.scol  = SCOL_W'(scol);
    numbers_q.push_back(n);
  endtask

  task automatic add_random(int num);
    logic [VALUE_W-1:0] v;
    int cnt;
    int ln;
    int sc;
    for (int i = 0; i < num; i++) begin
      case ($urandom_range(7))
        0: v = '0;
        1: v = '1;
        2: v = {1'b1, {(VALUE_W-1){1'b0}}} + VALUE_W'($urandom_range(3));
        3: v = VALUE_W'($urandom_range(999));
        4: v = -VALUE_W'($urandom_range(1, 999));
        default: v = $urandom;
      endcase
      // mostly legal counts and positions, some out of range
      cnt = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
      ln  = ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
      sc  = ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
      add_number(kind_e'($urandom_range(3)), v, cnt, ln, sc);
    end
  endtask

  task automatic wait_drained();
    while (numbers_q.size() != 0 || glyphs_q.size() != 0) @(negedge clk_i);
  endtask

  // Stimulus and end of run
  initial begin
    rst_ni              = 1'b0;
    num_if.valid        = 1'b0;
    num_if.kind         = '0;
    num_if.value        = '0;
    num_if.digit_count  = '0;
    num_if.line         = '0;
    num_if.start_column = '0;
    chr_if.ready        = 1'b0;
    send_idle_pct       = 15;
    recv_idle_pct       = 66;
    hold_reqs           = 0;
    hold_done           = 0;
    hold_left           = 0;
    mismatches          = 0;
    cycles              = 0;
    num_taken           = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, all modes, saturation, zero count, odd positions
    add_number(KIND_UDEC, 32'hFFFF_FFFF, 10, 1, 1);
    add_number(KIND_UDEC, 32'd0, 1, 2, 16);
    add_number(KIND_UDEC, 32'd1234567890, 5, 3, 4);
    add_number(KIND_UDEC, 32'd4000000000, 31, 4, 8);
    add_number(KIND_UDEC, 32'd77, 0, 1, 1);
    add_number(KIND_SDEC, 32'h8000_0000, 10, 1, 1);
    add_number(KIND_SDEC, 32'h7FFF_FFFF, 10, 2, 3);
    add_number(KIND_SDEC, 32'd0, 0, 3, 5);
    add_number(KIND_SDEC, 32'hFFFF_FFFF, 3, 4, 7);
    add_number(KIND_SDEC, 32'hFFFF_FF85, 16, 0, 31);
    add_number(KIND_HEX, 32'hDEAD_BEEF, 8, 1, 1);
    add_number(KIND_HEX, 32'hABCD_EF01, 31, 7, 0);
    add_number(KIND_HEX, 32'h0123_4567, 3, 2, 9);
    add_number(KIND_HEX, 32'hFFFF_FFFF, 0, 1, 1);
    add_number(KIND_BIN, 32'h0000_A5A5, 16, 3, 1);
    add_number(KIND_BIN, 32'hFFFF_FFFF, 31, 4, 31);
    add_number(KIND_BIN, 32'h0000_0001, 1, 0, 16);
    add_number(KIND_BIN, 32'h5555_5555, 0, 5, 2);
    add_number(KIND_UDEC, 32'd9, 10, 6, 31);
    add_number(KIND_SDEC, 32'h8000_0001, 10, 7, 0);

    // sender idles little, receiver a lot
    add_random(120);
    wait_drained();

    // the other way round
    send_idle_pct = 66;
    recv_idle_pct = 15;
    add_random(130);
    wait_drained();

    // no idling, with one long receiver hold-off while items keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(150);
    while (numbers_q.size() > 110) @(negedge clk_i);
    hold_reqs = hold_reqs + 1;
    wait_drained();

    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (mismatches == 0 && glyphs_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
